>>> design/assert_macros.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> design/mbsw_pkg.sv
package mbsw_pkg;

    localparam int NUM_PORTS = 3;
    localparam logic [3:0] PORT_LIMIT = 4'(NUM_PORTS);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
    localparam logic [15:0] REG_COUNT = 16'h0002;
    localparam logic [7:0] BYTE_COUNT = 8'h04;

    // byte positions within a frame
    localparam logic [3:0] POS_ADDR     = 4'd0;
    localparam logic [3:0] POS_FUNC     = 4'd1;
    localparam logic [3:0] POS_REG_HI   = 4'd2;
    localparam logic [3:0] POS_REG_LO   = 4'd3;
    localparam logic [3:0] POS_CNT_HI   = 4'd4;
    localparam logic [3:0] POS_CNT_LO   = 4'd5;
    localparam logic [3:0] POS_BYTES    = 4'd6;
    localparam logic [3:0] POS_SPD_1    = 4'd7;
    localparam logic [3:0] POS_SPD_0    = 4'd8;
    localparam logic [3:0] POS_SPD_3    = 4'd9;
    localparam logic [3:0] POS_SPD_2    = 4'd10;
    localparam logic [3:0] POS_CRC_LO   = 4'd11;
    localparam logic [3:0] POS_CRC_HI   = 4'd12;

    // configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_START_REG  = 1'b1;

    typedef struct packed {
        logic [2:0]  port;
        logic [31:0] speed;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] start_register;
    } frame_cfg_t;

endpackage

>>> design/mbsw_crc8.sv
module mbsw_crc8
    import mbsw_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

>>> design/mbsw_frame.sv
module mbsw_frame
    import mbsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_cfg_t  cfg,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  port,
    output logic [7:0]  tx_byte,
    output logic        last_byte
);

`include "assert_macros.svh"

    logic        busy_reg, busy_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    cmd_t        cur_reg, cur_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_port_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        advance;
    logic        at_end;
    logic [7:0]  byte_sel;
    logic [15:0] crc_upd;

    assign advance  = busy_reg && (!out_valid_reg || out_ready);
    assign at_end   = (pos_reg == POS_CRC_HI);
    assign cmd_take = cmd_valid && (!busy_reg || (advance && at_end));

    always_comb
    begin
        case (pos_reg)
            POS_ADDR:   byte_sel = cfg.slave_address;
            POS_FUNC:   byte_sel = FUNC_WRITE_MULTI;
            POS_REG_HI: byte_sel = cfg.start_register[15:8];
            POS_REG_LO: byte_sel = cfg.start_register[7:0];
            POS_CNT_HI: byte_sel = REG_COUNT[15:8];
            POS_CNT_LO: byte_sel = REG_COUNT[7:0];
            POS_BYTES:  byte_sel = BYTE_COUNT;
            POS_SPD_1:  byte_sel = cur_reg.speed[15:8];
            POS_SPD_0:  byte_sel = cur_reg.speed[7:0];
            POS_SPD_3:  byte_sel = cur_reg.speed[31:24];
            POS_SPD_2:  byte_sel = cur_reg.speed[23:16];
            POS_CRC_LO: byte_sel = crc_reg[7:0];
            POS_CRC_HI: byte_sel = crc_reg[15:8];
            default:    byte_sel = 8'h00;
        endcase
    end

    mbsw_crc8 u_crc
    (
        .crc_in  (crc_reg),
        .data    (byte_sel),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            pos_next       = pos_reg + 4'd1;
            if (pos_reg < POS_CRC_LO)
                crc_next = crc_upd;
            if (at_end)
                busy_next = 1'b0;
        end
        if (cmd_take)
        begin
            busy_next = 1'b1;
            pos_next  = POS_ADDR;
            crc_next  = CRC_INIT;
            cur_next  = cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_ADDR;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            out_port_reg <= cur_reg.port;
            out_byte_reg <= byte_sel;
            out_last_reg <= at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign port      = out_port_reg;
    assign tx_byte   = out_byte_reg;
    assign last_byte = out_last_reg;

    `ASSERT_IMPLY(a_pos_range, busy_reg, pos_reg <= POS_CRC_HI)
    `ASSERT_IMPLY(a_take_free, cmd_take, !busy_reg || (advance && at_end))
    `ASSERT_NEXT(a_last_mark, advance && at_end, out_valid_reg && out_last_reg)

endmodule

>>> design/modbus_speed_write_framer.sv
// Modbus RTU write-multiple-registers framer for speed commands.
// Input channel (in_valid/in_ready) takes a port_index and a signed 32-bit
// speed_value. Each command with port_index below NUM_PORTS becomes a
// 13-byte frame on the output channel (out_valid/out_ready): address,
// function 0x10, start register, count, byte count, speed low word then high
// word (each big-endian), CRC-16 low then high. last_byte marks byte 13.
// Commands with port_index at or above NUM_PORTS are taken and dropped.
// Config: cfg_we writes cfg_data into register cfg_index (0 slave address,
// 1 start register); write only while the block is idle.
// The first byte passes the command, sequencer and output byte registers.
// Throughput: one byte per cycle while the receiver is ready; the frame
// sequencer emits one byte per cycle unless stalled and a one-entry
// command register lets the next command wait while a frame is going out.
// Reset empties the command register and sequencer and restores slave
// address 1 and start register 274. When the receiver stalls, the output
// byte holds and the sequencer and command register wait.
module modbus_speed_write_framer
    import mbsw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         port_index,
    input  logic signed [31:0] speed_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         port,
    output logic [7:0]         tx_byte,
    output logic               last_byte
);

`include "assert_macros.svh"

    frame_cfg_t cfg_reg;
    logic       hold_valid_reg, hold_valid_next;
    cmd_t       hold_reg;
    logic       in_accept;
    logic       port_ok;
    logic       cmd_take;

    assign in_ready  = !hold_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign port_ok   = ({1'b0, port_index} < PORT_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address  <= 8'd1;
            cfg_reg.start_register <= 16'd274;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLAVE_ADDR: cfg_reg.slave_address  <= cfg_data[7:0];
                CFG_START_REG:  cfg_reg.start_register <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (cmd_take)
            hold_valid_next = 1'b0;
        if (in_accept && port_ok)
            hold_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && port_ok)
        begin
            hold_reg.port  <= port_index;
            hold_reg.speed <= speed_value;
        end
    end

    mbsw_frame u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (hold_valid_reg),
        .cmd       (hold_reg),
        .cmd_take  (cmd_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .port      (port),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

    `ASSERT_IMPLY(a_hold_port, hold_valid_reg, {1'b0, hold_reg.port} < PORT_LIMIT)
    `ASSERT_NEXT(a_take_clears, cmd_take, !hold_valid_reg)
    `ASSERT_NEXT(a_drop_bad_port, in_accept && !port_ok, !hold_valid_reg)

endmodule

>>> dv/testbench.sv
module testbench
    import mbsw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RX_HOLD_AFTER = 700;
    localparam int DRAIN_CYCLES = 6;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_PHASES = 5;
    localparam int FRAMES_PER_PHASE = 79;
    localparam int CRC_SPAN = 11;

    typedef enum logic [1:0] {ROW_CMD, ROW_DROP, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  port_no;
        logic [31:0] speed;
        logic        cfg_sel;
        logic [15:0] cfg_val;
    } stim_row_t;

    typedef struct {
        logic [2:0] port_no;
        logic [7:0] data;
        logic       last;
    } tx_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         port_index;
    logic signed [31:0] speed_value;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         port;
    logic [7:0]         tx_byte;
    logic               last_byte;

    modbus_speed_write_framer dut (.*);

    tx_word_t    frame_q [$];
    logic [7:0]  cur_slave_addr;
    logic [15:0] cur_start_reg;
    int          mismatches = 0;
    int          words_seen = 0;
    int          idle_cycles = 0;
    bit          tx_idle_on;
    bit          rx_idle_on;
    stim_row_t   directed_rows [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic predict_frame(input logic [2:0] p, input logic [31:0] s);
        logic [7:0]  body [0:CRC_SPAN-1];
        logic [15:0] crc;
        if (p >= NUM_PORTS)
            return;
        body = '{cur_slave_addr, FUNC_WRITE_MULTI, cur_start_reg[15:8], cur_start_reg[7:0],
                 REG_COUNT[15:8], REG_COUNT[7:0], BYTE_COUNT,
                 s[15:8], s[7:0], s[31:24], s[23:16]};
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++)
        begin
            crc = crc16_byte(crc, body[i]);
            frame_q.push_back('{p, body[i], 1'b0});
        end
        frame_q.push_back('{p, crc[7:0], 1'b0});
        frame_q.push_back('{p, crc[15:8], 1'b1});
    endtask

    function automatic stim_row_t cmd_row(logic [2:0] p, logic [31:0] s);
        return '{ROW_CMD, p, s, CFG_SLAVE_ADDR, 16'h0000};
    endfunction

    function automatic stim_row_t drop_row(logic [2:0] p, logic [31:0] s);
        return '{ROW_DROP, p, s, CFG_SLAVE_ADDR, 16'h0000};
    endfunction

    function automatic stim_row_t cfg_row(logic sel, logic [15:0] v);
        return '{ROW_CFG, 3'd0, 32'd0, sel, v};
    endfunction

    // called just after a falling edge; returns just after a falling edge, once the command has been taken
    task automatic send_cmd(input logic [2:0] p, input logic [31:0] s, input bit no_frame);
        int gap;
        gap = tx_idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        port_index = p;
        speed_value = s;
        do
            @(posedge clk);
        while (!in_ready);
        // out-of-range rows carry their expectation in the table: no frame
        if (!no_frame)
            predict_frame(p, s);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (frame_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic sel, input logic [15:0] v);
        cfg_we = 1'b1;
        cfg_index = sel;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == CFG_SLAVE_ADDR)
            cur_slave_addr = v[7:0];
        else
            cur_start_reg = v;
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : out_check
        tx_word_t got;
        tx_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{port, tx_byte, last_byte};
            words_seen++;
            if (frame_q.size() == 0)
                note_mismatch($sformatf("unexpected word: port %0d byte %h last %b",
                                        got.port_no, got.data, got.last));
            else
            begin
                want = frame_q.pop_front();
                if (got.port_no !== want.port_no || got.data !== want.data
                    || got.last !== want.last)
                    note_mismatch($sformatf(
                        "mismatch: want port %0d byte %h last %b, got port %0d byte %h last %b",
                        want.port_no, want.data, want.last, got.port_no, got.data, got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** modbus_speed_write_framer: FAILED **");
            $finish;
        end
    end

    initial begin : receiver
        int gap;
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && words_seen >= RX_HOLD_AFTER)
            begin
                // long stall so the command register fills and input backs up
                held = 1'b1;
                out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end
            gap = rx_idle_on ? gap_len() : 0;
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    initial begin : stimulus
        int          frames;
        logic [2:0]  p;
        logic [31:0] s;
        logic [15:0] addr_val;
        logic [15:0] reg_val;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SLAVE_ADDR;
        cfg_data = '0;
        in_valid = 1'b0;
        port_index = '0;
        speed_value = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        cur_slave_addr = 8'd1;
        cur_start_reg = 16'd274;

        directed_rows = '{
            cmd_row(3'd0, 32'h0000_0000),
            cmd_row(3'd1, 32'h7FFF_FFFF),
            cmd_row(3'd2, 32'h8000_0000),
            cmd_row(3'd2, 32'hFFFF_FFFF),
            drop_row(3'd3, 32'h0000_0005),
            drop_row(3'd7, 32'hFFFF_FFFF),
            cmd_row(3'd0, 32'h1234_5678),
            drop_row(3'd4, 32'h0000_0001),
            drop_row(3'd5, 32'h8000_0000),
            drop_row(3'd6, 32'h7FFF_FFFF),
            cmd_row(3'd1, 32'h0000_0001),
            cfg_row(CFG_SLAVE_ADDR, 16'h0000),
            cfg_row(CFG_START_REG, 16'h0000),
            cmd_row(3'd0, 32'h0000_0000),
            cmd_row(3'd2, 32'hFFFF_0000),
            cfg_row(CFG_SLAVE_ADDR, 16'hFFFF),
            cfg_row(CFG_START_REG, 16'hFFFF),
            cmd_row(3'd1, 32'h0000_FFFF),
            cmd_row(3'd0, 32'h8000_0001),
            cfg_row(CFG_SLAVE_ADDR, 16'h3A5C),
            cfg_row(CFG_START_REG, 16'hA55A),
            cmd_row(3'd2, 32'hA5A5_5A5A),
            cmd_row(3'd1, 32'h5A5A_A5A5)
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_CFG:
                begin
                    drain();
                    write_cfg(directed_rows[i].cfg_sel, directed_rows[i].cfg_val);
                end
                ROW_DROP: send_cmd(directed_rows[i].port_no, directed_rows[i].speed, 1'b1);
                default:  send_cmd(directed_rows[i].port_no, directed_rows[i].speed, 1'b0);
            endcase
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    addr_val = 16'h0000;
                    reg_val = 16'hFFFF;
                end
                1:
                begin
                    addr_val = 16'hFF00 | 16'h00FF;
                    reg_val = 16'h0000;
                end
                default:
                begin
                    addr_val = 16'($urandom);
                    reg_val = 16'($urandom);
                end
            endcase
            write_cfg(CFG_SLAVE_ADDR, addr_val);
            write_cfg(CFG_START_REG, reg_val);
            tx_idle_on = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            rx_idle_on = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            frames = 0;
            while (frames < FRAMES_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 8)
                    p = 3'($urandom_range(0, NUM_PORTS - 1));
                else
                    p = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 7))
                    6: s = 32'($urandom_range(0, 200)) - 32'd100;
                    7:
                    case ($urandom_range(0, 3))
                        0: s = 32'h7FFF_FFFF;
                        1: s = 32'h8000_0000;
                        2: s = 32'hFFFF_FFFF;
                        default: s = 32'h0000_0000;
                    endcase
                    default: s = $urandom;
                endcase
                send_cmd(p, s, 1'b0);
                if (p < NUM_PORTS)
                    frames++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("** modbus_speed_write_framer: PASSED **");
        else
            $display("** modbus_speed_write_framer: FAILED **");
        $finish;
    end

endmodule
